/* src/bb3_pkg.sv */
package bb3_pkg;

  localparam int SUM_W = 12;   // up to nine 8-bit samples
  localparam int CNT_W = 4;    // sample count 1..9
  localparam int HEIGHT_LIMIT = 4096;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // one pending result: channel sums, sample count, end-of-frame mark
  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]      n;
    logic                  frame_end;
  } entry_t;

  // floor(65536 / (2n)) for the rounded mean
  function automatic logic [15:0] recip(input logic [CNT_W-1:0] n);
    logic [15:0] v;
    case (n)
      4'd1:    v = 16'd32768;
      4'd2:    v = 16'd16384;
      4'd3:    v = 16'd10922;
      4'd4:    v = 16'd8192;
      4'd5:    v = 16'd6553;
      4'd6:    v = 16'd5461;
      4'd7:    v = 16'd4681;
      4'd8:    v = 16'd4096;
      4'd9:    v = 16'd3640;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/bb3_in_if.sv */
interface bb3_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

/* src/bb3_out_if.sv */
interface bb3_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;
  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

/* src/bb3_cfg_if.sv */
interface bb3_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/bb3_front.sv */
module bb3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  bb3_in_if.sink          in_chan,
  bb3_cfg_if.sink         cfg_chan,
  output logic            push_valid,
  output bb3_pkg::entry_t push_data,
  input  logic            push_ready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_PIX, S_EMIT1, S_EMIT2, S_DRAIN, S_DPUSH
  } state_t;

  state_t state_r;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [AW-1:0] wm1;
  logic [11:0] hm1;
  logic h2;

  logic [AW-1:0] col_r, drain_cnt_r, c_r, hi_r;
  logic [AW:0]   x_r;
  logic [11:0]   row_r, r_r;
  logic          draining_r, e2_r, fe_r;
  logic [23:0]   pix_r;
  logic [9:0]    cs_r [3][3];
  logic [10:0]   acc_r [3];
  logic [bb3_pkg::CNT_W-1:0] acc_n_r;

  logic [23:0] above_mem [MAX_WIDTH];
  logic [23:0] two_mem [MAX_WIDTH];
  logic [23:0] above_q, two_q;
  logic [AW-1:0] rd_addr;
  logic wr_en;

  logic [AW-1:0] c_now, d_now, lo_now, hi_now;
  logic [11:0] r_now;
  logic [9:0] new_cs [3];
  logic accept;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready = (state_r == S_IDLE);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    if (width_r == 11'd0) begin
      wm1 = '0;
    end else if (32'(width_r) > MAX_WIDTH) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(width_r - 11'd1);
    end
    if (height_r == 13'd0) begin
      hm1 = '0;
    end else if (32'(height_r) > bb3_pkg::HEIGHT_LIMIT) begin
      hm1 = 12'(bb3_pkg::HEIGHT_LIMIT - 1);
    end else begin
      hm1 = 12'(height_r - 13'd1);
    end
    h2 = (hm1 != 12'd0);
  end

  always_comb begin
    c_now  = (col_r < wm1) ? col_r : wm1;
    r_now  = (row_r < hm1) ? row_r : hm1;
    d_now  = (drain_cnt_r < wm1) ? drain_cnt_r : wm1;
    lo_now = (d_now != '0) ? d_now - AW'(1) : '0;
    hi_now = (d_now < wm1) ? d_now + AW'(1) : d_now;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      new_cs[k] = 10'(above_q[8*(2-k) +: 8]) + 10'(pix_r[8*(2-k) +: 8])
                + ((r_r >= 12'd2) ? 10'(two_q[8*(2-k) +: 8]) : 10'd0);
    end
  end

  always_comb begin
    rd_addr = x_r[AW-1:0];
    if (state_r == S_IDLE) begin
      rd_addr = in_chan.cmd ? lo_now : c_now;
    end
    wr_en = (state_r == S_PIX);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[c_r] <= pix_r;
      two_mem[c_r]   <= above_q;
    end
    above_q <= above_mem[rd_addr];
    two_q   <= two_mem[rd_addr];
  end

  // build the result handed to the queue
  always_comb begin
    logic full_row;
    full_row = (r_r >= 12'd2);
    push_valid = 1'b0;
    push_data.frame_end = 1'b0;
    push_data.n = '0;
    for (int k = 0; k < 3; k++) begin
      push_data.sum[k] = '0;
    end
    unique case (state_r)
      S_EMIT1: begin
        push_valid = 1'b1;
        for (int k = 0; k < 3; k++) begin
          push_data.sum[2-k] = 12'(cs_r[1][k]) + 12'(cs_r[2][k])
                             + ((c_r >= AW'(2)) ? 12'(cs_r[0][k]) : 12'd0);
        end
        if (c_r >= AW'(2)) begin
          push_data.n = full_row ? 4'd9 : 4'd6;
        end else begin
          push_data.n = full_row ? 4'd6 : 4'd4;
        end
      end
      S_EMIT2: begin
        push_valid = 1'b1;
        for (int k = 0; k < 3; k++) begin
          push_data.sum[2-k] = 12'(cs_r[2][k])
                             + ((c_r != '0) ? 12'(cs_r[1][k]) : 12'd0);
        end
        if (c_r != '0) begin
          push_data.n = full_row ? 4'd6 : 4'd4;
        end else begin
          push_data.n = full_row ? 4'd3 : 4'd2;
        end
      end
      S_DPUSH: begin
        push_valid = 1'b1;
        for (int k = 0; k < 3; k++) begin
          push_data.sum[2-k] = 12'(acc_r[k]);
        end
        push_data.n = acc_n_r;
        push_data.frame_end = fe_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= 11'd1024;
      height_r    <= 13'd768;
      col_r       <= '0;
      row_r       <= '0;
      drain_cnt_r <= '0;
      draining_r  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          cs_r[i][k] <= '0;
        end
      end
    end else begin
      if (cfg_chan.valid) begin
        unique case (bb3_pkg::reg_idx_t'(cfg_chan.index))
          bb3_pkg::REG_WIDTH:  width_r  <= cfg_chan.data[10:0];
          bb3_pkg::REG_HEIGHT: height_r <= cfg_chan.data;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!in_chan.cmd && !draining_r) begin
              pix_r   <= {in_chan.in_red, in_chan.in_green, in_chan.in_blue};
              c_r     <= c_now;
              r_r     <= r_now;
              state_r <= S_PIX;
            end else if (in_chan.cmd && draining_r) begin
              x_r     <= {1'b0, lo_now} + (AW+1)'(1);
              hi_r    <= hi_now;
              fe_r    <= (d_now == wm1);
              acc_n_r <= '0;
              for (int k = 0; k < 3; k++) begin
                acc_r[k] <= '0;
              end
              if (d_now == wm1) begin
                draining_r  <= 1'b0;
                drain_cnt_r <= '0;
              end else begin
                drain_cnt_r <= d_now + AW'(1);
              end
              state_r <= S_DRAIN;
            end
          end
        end
        S_PIX: begin
          cs_r[0] <= cs_r[1];
          cs_r[1] <= cs_r[2];
          cs_r[2] <= new_cs;
          e2_r <= (r_r != '0) && (c_r == wm1);
          if (c_r == wm1) begin
            col_r <= '0;
            if (r_r == hm1) begin
              row_r       <= '0;
              drain_cnt_r <= '0;
              draining_r  <= 1'b1;
            end else begin
              row_r <= r_r + 12'd1;
            end
          end else begin
            col_r <= c_r + AW'(1);
          end
          if ((r_r != '0) && (c_r != '0)) begin
            state_r <= S_EMIT1;
          end else if ((r_r != '0) && (c_r == wm1)) begin
            state_r <= S_EMIT2;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT1: begin
          if (push_ready) begin
            state_r <= e2_r ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (push_ready) begin
            state_r <= S_IDLE;
          end
        end
        S_DRAIN: begin
          // take the word read last cycle, fetch the next column
          for (int k = 0; k < 3; k++) begin
            acc_r[k] <= acc_r[k] + 11'(above_q[8*(2-k) +: 8])
                      + (h2 ? 11'(two_q[8*(2-k) +: 8]) : 11'd0);
          end
          acc_n_r <= acc_n_r + (h2 ? 4'd2 : 4'd1);
          if (x_r <= {1'b0, hi_r}) begin
            x_r <= x_r + (AW+1)'(1);
          end else begin
            state_r <= S_DPUSH;
          end
        end
        S_DPUSH: begin
          if (push_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/bb3_queue.sv */
module bb3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  bb3_pkg::entry_t push_data,
  output logic            push_ready,
  output logic            pop_valid,
  output bb3_pkg::entry_t pop_data,
  input  logic            pop
);

  bb3_pkg::entry_t slot_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] count_r;
  logic do_push, do_pop;

  assign push_ready = (count_r != 3'd4);
  assign pop_valid  = (count_r != 3'd0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 2'd1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      count_r <= count_r + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule

/* src/bb3_back.sv */
module bb3_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  bb3_pkg::entry_t pop_data,
  output logic            pop,
  bb3_out_if.source       out_chan
);

  logic        s1_v_r, s1_fe_r, out_v_r;
  logic [12:0] x_r [3];
  logic [28:0] prod_r [3];
  logic [4:0]  d_r;
  logic [7:0]  q_out [3];
  logic [7:0]  res_r [3];
  logic        fe_r;
  logic        ready2, load1;

  assign ready2 = !out_v_r || out_chan.ready;
  assign load1  = !s1_v_r || ready2;
  assign pop    = pop_valid && load1;

  assign out_chan.valid     = out_v_r;
  assign out_chan.out_red   = res_r[0];
  assign out_chan.out_green = res_r[1];
  assign out_chan.out_blue  = res_r[2];
  assign out_chan.frame_end = fe_r;

  // estimate is exact or one low; one compare fixes it
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [12:0] q0, rem, q;
      logic [17:0] m;
      q0  = prod_r[k][28:16];
      m   = 18'(q0) * 18'(d_r);
      rem = x_r[k] - m[12:0];
      q   = (rem >= 13'(d_r)) ? q0 + 13'd1 : q0;
      q_out[k] = (q > 13'd255) ? 8'd255 : q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && pop_valid) begin
      for (int k = 0; k < 3; k++) begin
        logic [12:0] x;
        x = {pop_data.sum[2-k], 1'b0} + 13'(pop_data.n);
        x_r[k]    <= x;
        prod_r[k] <= 29'(x) * 29'(bb3_pkg::recip(pop_data.n));
      end
      d_r     <= {pop_data.n, 1'b0};
      s1_fe_r <= pop_data.frame_end;
    end
    if (ready2 && s1_v_r) begin
      res_r <= q_out;
      fe_r  <= s1_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load1) begin
        s1_v_r <= pop_valid;
      end
      if (ready2) begin
        out_v_r <= s1_v_r;
      end
    end
  end

endmodule

/* src/box_blur_3x3_edge_clipped_unit.sv */
// 3x3 box blur on an RGB raster stream, window clipped at the borders, each
// channel the sample mean rounded half up. A pixel word gets a registered
// line-store read, then pushes each result it releases (none to two) into
// the result queue, one per cycle while the queue has room; a drain word
// reads the one to three columns of its window from the line stores in turn
// and pushes one result. No new word is taken until the last is through.
// Ignored words (drain while not draining, pixel while draining) are dropped.
// Results pass a four-entry queue and a two-stage divide pipeline. Output lags
// input by one row and one column; after the last pixel of a frame, send one
// drain word per column to release the final row, the last with frame_end.
module box_blur_3x3_edge_clipped_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic    clk,
  input  logic    rst_n,
  bb3_in_if.sink  in_chan,
  bb3_out_if.source out_chan,
  bb3_cfg_if.sink cfg_chan
);

  logic            push_valid, push_ready, pop_valid, pop;
  bb3_pkg::entry_t push_data, pop_data;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg_chan   (cfg_chan),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  bb3_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  bb3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule
